### hw/rtl/dbuq_pkg.sv
// ----------------------------------------------------------------------------
// dbuq_pkg
// Types, codes and constants shared by the double-buffered update queue.
// ----------------------------------------------------------------------------
package dbuq_pkg;

  localparam int unsigned DBUQ_PAGE_DEPTH = 32;
  // Largest page depth the slot fields are sized for.
  localparam int unsigned PAGE_DEPTH_MAX  = 64;
  localparam int unsigned SLOT_W_MAX      = 6;
  localparam int unsigned MAX_RESULTS     = 32;
  localparam int unsigned N_W             = 6;
  localparam int unsigned CFG_W           = 6;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned RAW_W           = 18;
  localparam int unsigned VALUE_W         = 17;
  localparam logic [VALUE_W-1:0] Q_ONE    = 17'h10000;
  localparam logic [CFG_W-1:0] CAP_RESET  = 6'd32;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_SWAP  = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_CAPACITY = 1'b0,
    CFG_APPLY_ENABLED = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]         target;
    logic [7:0]         index;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // One emission job: n entries of a page, n == 0 means a single empty result.
  typedef struct packed {
    logic           page;
    logic [N_W-1:0] n;
    logic           ovf;
  } job_t;

  typedef struct packed {
    logic                  en;
    logic                  page;
    logic [SLOT_W_MAX-1:0] slot;
    entry_t                data;
  } mem_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic back_busy;
  } queue_status_t;

endpackage

### hw/rtl/dbuq_front.sv
// ----------------------------------------------------------------------------
// dbuq_front
// Accepts commands, keeps page bookkeeping and issues writes and emit jobs.
// ----------------------------------------------------------------------------
module dbuq_front import dbuq_pkg::*; #(
  parameter int unsigned PAGE_DEPTH = DBUQ_PAGE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [7:0]            target_id_i,
  input  logic [7:0]            param_index_i,
  input  logic signed [RAW_W-1:0] raw_value_i,
  input  logic [N_W-1:0]        drain_limit_i,
  input  queue_status_t         status_i,
  output logic                  job_valid_o,
  output job_t                  job_o,
  output mem_wr_t               mem_wr_o
);

  localparam int unsigned CW = $clog2(PAGE_DEPTH + 1);

  logic          wsel_q, wsel_d;
  logic [CW-1:0] cnt_q [2];
  logic [CW-1:0] cnt_d [2];
  logic [1:0]    ovf_q, ovf_d;
  logic [CFG_W-1:0] cap_cfg_q;
  logic          apply_q;

  cmd_e          cmd;
  logic          w, r, accept;
  logic [CW-1:0] cap, pos;
  logic [6:0]    n7;

  function automatic logic [VALUE_W-1:0] clamp(input logic signed [RAW_W-1:0] v);
    logic [VALUE_W-1:0] res;
    if (v[RAW_W-1]) begin
      res = '0;
    end else if (v[RAW_W-2:0] > Q_ONE) begin
      res = Q_ONE;
    end else begin
      res = v[VALUE_W-1:0];
    end
    return res;
  endfunction

  assign cmd = cmd_e'(command_i);
  assign w   = wsel_q;
  assign r   = ~wsel_q;

  // Pushes wait for all pending emissions, since a swap may have turned the
  // page being read into the new write page.
  always_comb begin
    unique case (cmd)
      CMD_PUSH:            in_ready_o = status_i.empty && !status_i.back_busy;
      CMD_SWAP, CMD_DRAIN: in_ready_o = !status_i.full;
      default:             in_ready_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    if ({1'b0, cap_cfg_q} < 7'(PAGE_DEPTH)) begin
      cap = CW'(cap_cfg_q);
    end else begin
      cap = CW'(PAGE_DEPTH);
    end
  end

  always_comb begin
    wsel_d      = wsel_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    mem_wr_o    = '0;
    pos         = cnt_q[w];
    n7          = '0;
    if (accept) begin
      unique case (cmd)
        CMD_PUSH: begin
          if (cap == '0) begin
            ovf_d[w] = 1'b1;
          end else begin
            if (pos >= cap) begin
              ovf_d[w] = 1'b1;
              pos      = cap - CW'(1);
            end
            mem_wr_o.en          = 1'b1;
            mem_wr_o.page        = w;
            mem_wr_o.slot        = SLOT_W_MAX'(pos);
            mem_wr_o.data.target = target_id_i;
            mem_wr_o.data.index  = param_index_i;
            mem_wr_o.data.value  = clamp(raw_value_i);
            cnt_d[w]             = pos + CW'(1);
          end
        end
        CMD_SWAP: begin
          job_valid_o = 1'b1;
          if (cnt_q[w] == '0 && !ovf_q[w]) begin
            job_o.page = r;
            job_o.n    = '0;
            job_o.ovf  = ovf_q[r];
          end else begin
            cnt_d[r] = '0;
            ovf_d[r] = 1'b0;
            wsel_d   = r;
            n7       = apply_q ? 7'(cnt_q[w]) : 7'd0;
            if (n7 > 7'(MAX_RESULTS)) n7 = 7'(MAX_RESULTS);
            job_o.page = w;
            job_o.n    = N_W'(n7);
            job_o.ovf  = ovf_q[w];
          end
        end
        CMD_DRAIN: begin
          job_valid_o = 1'b1;
          n7 = 7'(cnt_q[r]);
          if ({1'b0, drain_limit_i} < n7) n7 = {1'b0, drain_limit_i};
          if (n7 > 7'(MAX_RESULTS)) n7 = 7'(MAX_RESULTS);
          job_o.page = r;
          job_o.n    = N_W'(n7);
          job_o.ovf  = ovf_q[r];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsel_q    <= 1'b0;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      ovf_q     <= '0;
      cap_cfg_q <= CAP_RESET;
      apply_q   <= 1'b0;
    end else begin
      wsel_q <= wsel_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_PAGE_CAPACITY: cap_cfg_q <= cfg_wdata_i;
          CFG_APPLY_ENABLED: apply_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### hw/rtl/dbuq_job_fifo.sv
// ----------------------------------------------------------------------------
// dbuq_job_fifo
// Two-entry queue of emit jobs between the front and the back.
// ----------------------------------------------------------------------------
module dbuq_job_fifo import dbuq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o,
  output logic full_o
);

  job_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

### hw/rtl/dbuq_back.sv
// ----------------------------------------------------------------------------
// dbuq_back
// Page memory and emit sequencer: reads one entry per cycle into the output while the output is not stalled.
// ----------------------------------------------------------------------------
module dbuq_back import dbuq_pkg::*; #(
  parameter int unsigned PAGE_DEPTH = DBUQ_PAGE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mem_wr_t            mem_wr_i,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               job_take_o,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               entry_valid_o,
  output logic [7:0]         out_target_o,
  output logic [7:0]         out_index_o,
  output logic [VALUE_W-1:0] out_value_o,
  output logic               read_overflow_o,
  output logic               last_o
);

  localparam int unsigned IW = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;

  entry_t mem_q [2][PAGE_DEPTH];

  logic           act_q, act_d;
  job_t           job_q, job_d;
  logic [N_W-1:0] k_q, k_d;

  logic   rd_v_q, rd_v_d, rd_ent_q, rd_ent_d, rd_last_q, rd_last_d, rd_ovf_q, rd_ovf_d;
  entry_t rd_data_q;

  logic   out_free, issue, issue_last;

  assign out_free   = !out_valid_o || out_ready_i;
  assign issue      = act_q && (!rd_v_q || out_free);
  assign issue_last = (job_q.n == '0) || (k_q + N_W'(1) == job_q.n);
  assign job_take_o = !act_q && job_valid_i;
  assign busy_o     = act_q;

  always_comb begin
    act_d     = act_q;
    job_d     = job_q;
    k_d       = k_q;
    rd_v_d    = rd_v_q;
    rd_ent_d  = rd_ent_q;
    rd_last_d = rd_last_q;
    rd_ovf_d  = rd_ovf_q;
    if (job_take_o) begin
      act_d = 1'b1;
      job_d = job_i;
      k_d   = '0;
    end
    if (issue) begin
      rd_v_d    = 1'b1;
      rd_ent_d  = job_q.n != '0;
      rd_last_d = issue_last;
      rd_ovf_d  = job_q.ovf;
      k_d       = k_q + N_W'(1);
      if (issue_last) act_d = 1'b0;
    end else if (rd_v_q && out_free) begin
      rd_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) mem_q[mem_wr_i.page][mem_wr_i.slot[IW-1:0]] <= mem_wr_i.data;
    if (issue && job_q.n != '0) rd_data_q <= mem_q[job_q.page][k_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      entry_valid_o   <= rd_ent_q;
      out_target_o    <= rd_ent_q ? rd_data_q.target : 8'd0;
      out_index_o     <= rd_ent_q ? rd_data_q.index : 8'd0;
      out_value_o     <= rd_ent_q ? rd_data_q.value : '0;
      read_overflow_o <= rd_ovf_q;
      last_o          <= rd_last_q;
    end
    job_q     <= job_d;
    rd_ent_q  <= rd_ent_d;
    rd_last_q <= rd_last_d;
    rd_ovf_q  <= rd_ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      act_q  <= act_d;
      k_q    <= k_d;
      rd_v_q <= rd_v_d;
      if (out_free) out_valid_o <= rd_v_q;
    end
  end

endmodule

### hw/rtl/double_buffered_update_queue.sv
// ----------------------------------------------------------------------------
// double_buffered_update_queue
// Ping-pong pages of parameter updates with push, swap and drain commands.
// ----------------------------------------------------------------------------
//   channel  signals                           direction
//   in       in_valid_i / in_ready_o + fields  command transactions
//   out      out_valid_o / out_ready_i + fields result transactions
//   cfg      cfg_we_i, cfg_index_i, cfg_wdata_i register writes
//
// A push can follow every cycle while nothing is pending to emit; it waits
// until queued emissions of earlier swaps and drains end.
// Swap and drain produce results at one per cycle from the page memory read
// port while the output is not stalled; a two-entry job queue lets the
// front take up to two of them ahead. Reset clears counts, flags and the
// page select; the page memory is not cleared.
module double_buffered_update_queue import dbuq_pkg::*; #(
  parameter int unsigned PAGE_DEPTH = DBUQ_PAGE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              command_i,
  input  logic [7:0]              target_id_i,
  input  logic [7:0]              param_index_i,
  input  logic signed [RAW_W-1:0] raw_value_i,
  input  logic [N_W-1:0]          drain_limit_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    entry_valid_o,
  output logic [7:0]              out_target_o,
  output logic [7:0]              out_index_o,
  output logic [VALUE_W-1:0]      out_value_o,
  output logic                    read_overflow_o,
  output logic                    last_o
);

  queue_status_t status;
  logic          job_push, job_take, fifo_valid, fifo_full, back_busy;
  job_t          job_new, job_head;
  mem_wr_t       mem_wr;

  assign status = '{full: fifo_full, empty: !fifo_valid, back_busy: back_busy};

  dbuq_front #(.PAGE_DEPTH(PAGE_DEPTH)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .command_i, .target_id_i, .param_index_i,
    .raw_value_i, .drain_limit_i,
    .status_i    (status),
    .job_valid_o (job_push),
    .job_o       (job_new),
    .mem_wr_o    (mem_wr)
  );

  dbuq_job_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i      (job_push),
    .push_data_i (job_new),
    .pop_i       (job_take),
    .valid_o     (fifo_valid),
    .data_o      (job_head),
    .full_o      (fifo_full)
  );

  dbuq_back #(.PAGE_DEPTH(PAGE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .mem_wr_i    (mem_wr),
    .job_valid_i (fifo_valid),
    .job_i       (job_head),
    .job_take_o  (job_take),
    .busy_o      (back_busy),
    .out_valid_o, .out_ready_i, .entry_valid_o, .out_target_o, .out_index_o,
    .out_value_o, .read_overflow_o, .last_o
  );

endmodule

### tb/double_buffered_update_queue_checker.sv
// ----------------------------------------------------------------------------
// double_buffered_update_queue_checker
// Watches the command, result and register channels of the update queue,
// keeps its own copy of the two pages and flags, predicts the results of each
// accepted command and compares every accepted result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module double_buffered_update_queue_checker import dbuq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_o,
  input  logic [1:0]              command_i,
  input  logic [7:0]              target_id_i,
  input  logic [7:0]              param_index_i,
  input  logic signed [RAW_W-1:0] raw_value_i,
  input  logic [N_W-1:0]          drain_limit_i,
  input  logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  logic                    entry_valid_o,
  input  logic [7:0]              out_target_o,
  input  logic [7:0]              out_index_o,
  input  logic [VALUE_W-1:0]      out_value_o,
  input  logic                    read_overflow_o,
  input  logic                    last_o,
  output int unsigned             mismatches_o,
  output int unsigned             pending_o
);

  typedef struct packed {
    logic               entry_valid;
    logic [7:0]         target;
    logic [7:0]         index;
    logic [VALUE_W-1:0] value;
    logic               ovf;
    logic               last;
  } update_result_t;

  update_result_t expected_results [$];
  update_result_t oldest;

  entry_t      page_mem [2][DBUQ_PAGE_DEPTH];
  int unsigned page_cnt [2];
  logic        page_ovf [2];
  logic        wr_page;
  logic [CFG_W-1:0] capacity_reg;
  logic        apply_reg;
  int unsigned mismatches;

  int unsigned usable, slot, ready_cnt, lim, n, p, s;
  logic        wp, rp;
  logic [VALUE_W-1:0] clamped;

  // Queues the results that emitting cnt entries of page pg gives; cnt == 0 is
  // the lone empty result.
  task automatic queue_page_results(input logic pg, input int unsigned cnt);
    update_result_t r;
    int unsigned i;
    if (cnt > MAX_RESULTS) cnt = MAX_RESULTS;
    if (cnt == 0) begin
      r = '0;
      r.ovf = page_ovf[pg];
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      for (i = 0; i < cnt; i++) begin
        r.entry_valid = 1'b1;
        r.target = page_mem[pg][i].target;
        r.index = page_mem[pg][i].index;
        r.value = page_mem[pg][i].value;
        r.ovf = page_ovf[pg];
        r.last = (i + 1 == cnt);
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_reg = CAP_RESET;
      apply_reg = 1'b0;
      wr_page = 1'b0;
      for (p = 0; p < 2; p++) begin
        page_cnt[p] = 0;
        page_ovf[p] = 1'b0;
        for (s = 0; s < DBUQ_PAGE_DEPTH; s++) page_mem[p][s] = '0;
      end
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PAGE_CAPACITY: capacity_reg = cfg_wdata_i;
          CFG_APPLY_ENABLED: apply_reg = cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_o) begin
        wp = wr_page;
        rp = ~wr_page;
        usable = (32'(capacity_reg) < DBUQ_PAGE_DEPTH) ? 32'(capacity_reg) : DBUQ_PAGE_DEPTH;
        case (command_i)
          CMD_PUSH: begin
            if (raw_value_i < 0) clamped = '0;
            else if (raw_value_i > 18'sd65536) clamped = Q_ONE;
            else clamped = raw_value_i[VALUE_W-1:0];
            if (usable == 0) begin
              page_ovf[wp] = 1'b1;
            end else begin
              slot = page_cnt[wp];
              // A full page keeps overwriting its last usable slot.
              if (slot >= usable) begin
                page_ovf[wp] = 1'b1;
                slot = usable - 1;
              end
              page_mem[wp][slot].target = target_id_i;
              page_mem[wp][slot].index = param_index_i;
              page_mem[wp][slot].value = clamped;
              page_cnt[wp] = slot + 1;
            end
          end
          CMD_SWAP: begin
            ready_cnt = page_cnt[wp];
            if (ready_cnt == 0 && !page_ovf[wp]) begin
              queue_page_results(rp, 0);
            end else begin
              page_cnt[rp] = 0;
              page_ovf[rp] = 1'b0;
              wr_page = rp;
              queue_page_results(wp, apply_reg ? ready_cnt : 0);
            end
          end
          CMD_DRAIN: begin
            lim = 32'(drain_limit_i);
            n = page_cnt[rp];
            if (lim < n) n = lim;
            queue_page_results(rp, n);
          end
          default: ;
        endcase
      end

      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expected result waiting");
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("entry_valid", 32'(oldest.entry_valid), 32'(entry_valid_o));
          check_field("out_target", 32'(oldest.target), 32'(out_target_o));
          check_field("out_index", 32'(oldest.index), 32'(out_index_o));
          check_field("out_value", 32'(oldest.value), 32'(out_value_o));
          check_field("read_overflow", 32'(oldest.ovf), 32'(read_overflow_o));
          check_field("last", 32'(oldest.last), 32'(last_o));
        end
      end
    end
    pending_o = expected_results.size();
    mismatches_o = mismatches;
  end

endmodule

### tb/double_buffered_update_queue_tb.sv
// ----------------------------------------------------------------------------
// double_buffered_update_queue_tb
// Drives push, swap and drain transactions through the update queue under
// several page capacities and apply settings, with random stalls on both
// channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module double_buffered_update_queue_tb;
  import dbuq_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              command_i;
  logic [7:0]              target_id_i;
  logic [7:0]              param_index_i;
  logic signed [RAW_W-1:0] raw_value_i;
  logic [N_W-1:0]          drain_limit_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    entry_valid_o;
  logic [7:0]              out_target_o;
  logic [7:0]              out_index_o;
  logic [VALUE_W-1:0]      out_value_o;
  logic                    read_overflow_o;
  logic                    last_o;

  int unsigned mismatches;
  int unsigned pending;

  logic        idle_on;
  logic        hold_go;
  int unsigned hold_left;
  int unsigned stall_left;

  int unsigned phase_cap [8] = '{32, 1, 5, 0, 32, 17, 3, 32};
  logic        phase_apply [8] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  int unsigned ph, phase_items, burst;

  double_buffered_update_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .target_id_i    (target_id_i),
    .param_index_i  (param_index_i),
    .raw_value_i    (raw_value_i),
    .drain_limit_i  (drain_limit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .entry_valid_o  (entry_valid_o),
    .out_target_o   (out_target_o),
    .out_index_o    (out_index_o),
    .out_value_o    (out_value_o),
    .read_overflow_o(read_overflow_o),
    .last_o         (last_o)
  );

  double_buffered_update_queue_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .target_id_i    (target_id_i),
    .param_index_i  (param_index_i),
    .raw_value_i    (raw_value_i),
    .drain_limit_i  (drain_limit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .entry_valid_o  (entry_valid_o),
    .out_target_o   (out_target_o),
    .out_index_o    (out_index_o),
    .out_value_o    (out_value_o),
    .read_overflow_o(read_overflow_o),
    .last_o         (last_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Raw values: full range, the clamp window and the clamp boundaries.
  function automatic logic signed [RAW_W-1:0] pick_raw();
    logic signed [RAW_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = RAW_W'($urandom_range(0, 262143));
      1: v = RAW_W'($urandom_range(0, 65536));
      2: begin
        case ($urandom_range(0, 7))
          0: v = -18'sd131072;
          1: v = -18'sd1;
          2: v = 18'sd0;
          3: v = 18'sd1;
          4: v = 18'sd65535;
          5: v = 18'sd65536;
          6: v = 18'sd65537;
          default: v = 18'sd131071;
        endcase
      end
      default: v = RAW_W'($urandom_range(0, 131071));
    endcase
    return v;
  endfunction

  // Offers one command transaction and returns once it has been accepted.
  task automatic send_item(input cmd_e cmd, input logic [7:0] tgt, input logic [7:0] idx,
                           input logic signed [RAW_W-1:0] raw, input logic [N_W-1:0] lim);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i     <= cmd;
    target_id_i   <= tgt;
    param_index_i <= idx;
    raw_value_i   <= raw;
    drain_limit_i <= lim;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Register writes happen only once every expected result is back and the
  // block has had time to finish any trailing push.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = 300;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_PAGE_CAPACITY;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    command_i     = CMD_PUSH;
    target_id_i   = '0;
    param_index_i = '0;
    raw_value_i   = '0;
    drain_limit_i = '0;
    idle_on       = 1'b1;
    hold_go       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);

    // Reset settings: capacity 32, apply off.
    send_item(CMD_DRAIN, 8'd0, 8'd0, 18'sd0, 6'd0);
    send_item(CMD_SWAP, 8'd0, 8'd0, 18'sd0, 6'd0);
    send_item(CMD_PUSH, 8'd255, 8'd0, -18'sd131072, 6'd0);
    send_item(CMD_PUSH, 8'd0, 8'd255, 18'sd131071, 6'd63);
    send_item(CMD_PUSH, 8'd170, 8'd85, 18'sd65537, 6'd0);
    send_item(CMD_PUSH, 8'd85, 8'd170, 18'sd65536, 6'd0);
    send_item(CMD_PUSH, 8'd1, 8'd2, -18'sd1, 6'd0);
    send_item(CMD_PUSH, 8'd3, 8'd4, 18'sd65535, 6'd0);
    send_item(CMD_RSVD, 8'd255, 8'd255, -18'sd1, 6'd63);
    // With apply off the swap flips the pages but returns only the empty result.
    send_item(CMD_SWAP, 8'd0, 8'd0, 18'sd0, 6'd0);
    send_item(CMD_DRAIN, 8'd0, 8'd0, 18'sd0, 6'd63);
    send_item(CMD_DRAIN, 8'd0, 8'd0, 18'sd0, 6'd2);
    send_item(CMD_DRAIN, 8'd0, 8'd0, 18'sd0, 6'd0);

    // Zero capacity: pushes only raise the overflow flag.
    write_reg(CFG_PAGE_CAPACITY, 6'd0);
    write_reg(CFG_APPLY_ENABLED, 6'd1);
    send_item(CMD_PUSH, 8'd9, 8'd9, 18'sd1000, 6'd0);
    send_item(CMD_SWAP, 8'd0, 8'd0, 18'sd0, 6'd0);
    send_item(CMD_DRAIN, 8'd0, 8'd0, 18'sd0, 6'd32);

    // A full page overwrites its last slot.
    write_reg(CFG_PAGE_CAPACITY, 6'd2);
    repeat (3) send_item(CMD_PUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         pick_raw(), 6'd0);
    send_item(CMD_SWAP, 8'd0, 8'd0, 18'sd0, 6'd0);

    // Lowering the capacity below the count clips the page on the next push.
    write_reg(CFG_PAGE_CAPACITY, 6'd3);
    repeat (3) send_item(CMD_PUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         pick_raw(), 6'd0);
    write_reg(CFG_PAGE_CAPACITY, 6'd1);
    send_item(CMD_PUSH, 8'd77, 8'd66, 18'sd40000, 6'd0);
    send_item(CMD_SWAP, 8'd0, 8'd0, 18'sd0, 6'd0);

    for (ph = 0; ph < 8; ph++) begin
      write_reg(CFG_PAGE_CAPACITY, CFG_W'(phase_cap[ph]));
      write_reg(CFG_APPLY_ENABLED, CFG_W'(phase_apply[ph]));

      if (ph == 7) begin
        // Fill the pipeline while the result side holds off for a long time.
        @(posedge clk_i);
        idle_on = 1'b0;
        repeat (20) send_item(CMD_PUSH, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), pick_raw(), 6'd0);
        @(posedge clk_i);
        hold_go = 1'b1;
        send_item(CMD_SWAP, 8'd0, 8'd0, 18'sd0, 6'd0);
        repeat (3) send_item(CMD_DRAIN, 8'd0, 8'd0, 18'sd0, 6'd32);
        send_item(CMD_PUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  pick_raw(), 6'd0);
        send_item(CMD_SWAP, 8'd0, 8'd0, 18'sd0, 6'd0);
      end

      // Mostly batches of pushes closed by a swap, with drains and noise mixed in.
      phase_items = 0;
      while (phase_items < 32) begin
        if ($urandom_range(0, 3) == 0) burst = $urandom_range(0, phase_cap[ph] + 4);
        else burst = $urandom_range(0, 4);
        repeat (burst) send_item(CMD_PUSH, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), pick_raw(),
                                 N_W'($urandom_range(0, 32)));
        case ($urandom_range(0, 9))
          0, 1: send_item(CMD_DRAIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          pick_raw(), N_W'($urandom_range(0, 32)));
          2: send_item(cmd_e'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), pick_raw(), N_W'($urandom_range(0, 32)));
          default: send_item(CMD_SWAP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             pick_raw(), N_W'($urandom_range(0, 32)));
        endcase
        phase_items += burst + 1;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
